/* rtl/ffd_pkg.sv */
`timescale 1ns / 1ps

package ffd_pkg;

	localparam int unsigned PAYLOAD_BYTES = 24;
	localparam int unsigned WORD_COUNT    = 6;
	localparam int unsigned IDX_W         = 5;

	localparam logic [7:0] HDR_FIRST  = 8'h0D;
	localparam logic [7:0] HDR_SECOND = 8'h0A;
	localparam logic [7:0] TRL_FIRST  = 8'h0A;
	localparam logic [7:0] TRL_SECOND = 8'h0D;

	localparam logic [1:0] LAMP_LEAVE = 2'd0;
	localparam logic [1:0] LAMP_ON    = 2'd1;
	localparam logic [1:0] LAMP_OFF   = 2'd2;

	// A completed frame as handed from the parser to the result register.
	typedef struct packed {
		logic                        done;
		logic [WORD_COUNT-1:0][31:0] words;
	} frame_t;

endpackage

/* rtl/ffd_parser.sv */
`timescale 1ns / 1ps

module ffd_parser
	import ffd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output frame_t     frame
);

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_HDR2    = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_TRL1    = 3'd3,
		PH_TRL2    = 3'd4
	} phase_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

	phase_t           phase_q;
	logic [IDX_W-1:0] index_q;
	logic [7:0]       payload_q [PAYLOAD_BYTES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			index_q <= '0;
		end else if (step) begin
			case (phase_q)
				PH_HDR2: begin
					index_q <= '0;
					phase_q <= (rx_byte == HDR_SECOND) ? PH_PAYLOAD : PH_HUNT;
				end
				PH_PAYLOAD: begin
					if (index_q == LAST_IDX) begin
						index_q <= '0;
						phase_q <= PH_TRL1;
					end else begin
						index_q <= index_q + 1'b1;
					end
				end
				PH_TRL1: phase_q <= (rx_byte == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
				PH_TRL2: phase_q <= PH_HUNT;
				default: phase_q <= (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
			endcase
		end
	end

	// Payload bytes enter at the top and move down one place per byte, so after
	// a full payload the first byte of the frame sits in entry 0.
	always_ff @(posedge clk) begin
		if (step && phase_q == PH_PAYLOAD) begin
			for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
				payload_q[i] <= payload_q[i+1];
			end
			payload_q[PAYLOAD_BYTES-1] <= rx_byte;
		end
	end

	always_comb begin
		frame.done = step && phase_q == PH_TRL2 && rx_byte == TRL_SECOND;
		for (int k = 0; k < WORD_COUNT; k++) begin
			frame.words[k] = {payload_q[4*k+3], payload_q[4*k+2],
				payload_q[4*k+1], payload_q[4*k]};
		end
	end

endmodule

/* rtl/ffd_result.sv */
`timescale 1ns / 1ps

module ffd_result
	import ffd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  frame_t      frame,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [31:0] word_yaw,
	output logic [31:0] word_roll,
	output logic [31:0] word_pitch,
	output logic [31:0] word_pos_x,
	output logic [31:0] word_pos_y,
	output logic [31:0] word_turn_rate,
	output logic [1:0]  lamp_action
);

	logic       valid_q;
	logic [1:0] action;
	logic       z0, z3, z4;

	// Sign bit is ignored, so both signed zeros count as zero.
	always_comb begin
		z0 = frame.words[0][30:0] == '0;
		z3 = frame.words[3][30:0] == '0;
		z4 = frame.words[4][30:0] == '0;
		if (!z0 && !z3 && !z4) begin
			action = LAMP_ON;
		end else if (z0 && z3 && z4) begin
			action = LAMP_OFF;
		end else begin
			action = LAMP_LEAVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (frame.done) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.done) begin
			word_yaw       <= frame.words[0];
			word_roll      <= frame.words[1];
			word_pitch     <= frame.words[2];
			word_pos_x     <= frame.words[3];
			word_pos_y     <= frame.words[4];
			word_turn_rate <= frame.words[5];
			lamp_action    <= action;
		end
	end

	assign out_valid = valid_q;

endmodule

/* rtl/fixed_frame_deframer_six_words_core.sv */
`timescale 1ns / 1ps

// Fixed-length frame deframer, six words per frame.
// Input channel: in_valid / in_ready carry one received byte (rx_byte) per
// transaction. The block hunts for the header 0x0D 0x0A, collects 24 payload
// bytes and checks the trailer 0x0A 0x0D. Any unexpected byte sends it back
// to the hunt.
// Output channel: out_valid / out_ready carry one transaction per good frame:
// six little-endian 32-bit words and lamp_action (0 leave, 1 on, 2 off).
// Throughput is one byte per cycle while the output is not stalled. A byte
// is held in the input register and parsed from there, and a finished frame
// is captured in the result register, which drives the output.
// While a finished frame waits on out_ready, the held byte is not parsed and
// in_ready drops once the input register is full; parsing resumes in the
// cycle the frame is taken.
// Reset clears the input and output valid flags and puts the parser in hunt.
module fixed_frame_deframer_six_words_core
	import ffd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] word_yaw,
	output logic [31:0] word_roll,
	output logic [31:0] word_pitch,
	output logic [31:0] word_pos_x,
	output logic [31:0] word_pos_y,
	output logic [31:0] word_turn_rate,
	output logic [1:0]  lamp_action
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	frame_t     frame;

	// The held byte may be parsed only when the result register can take a frame.
	assign step     = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	ffd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.frame   (frame)
	);

	ffd_result u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame          (frame),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.word_yaw       (word_yaw),
		.word_roll      (word_roll),
		.word_pitch     (word_pitch),
		.word_pos_x     (word_pos_x),
		.word_pos_y     (word_pos_y),
		.word_turn_rate (word_turn_rate),
		.lamp_action    (lamp_action)
	);

endmodule

/* tb/sv/fixed_frame_deframer_six_words_core_tb.sv */
`timescale 1ns / 1ps

module fixed_frame_deframer_six_words_core_tb
	import ffd_pkg::*;
();

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_BYTES = 700;
	localparam int RANDOM_MIN_FRAMES = 15;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HDR2,
		PH_PAYLOAD,
		PH_TRL1,
		PH_TRL2
	} rx_phase_t;

	typedef struct packed {
		logic [WORD_COUNT-1:0][31:0] words;
		logic [1:0]                  lamp;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] word_yaw;
	logic [31:0] word_roll;
	logic [31:0] word_pitch;
	logic [31:0] word_pos_x;
	logic [31:0] word_pos_y;
	logic [31:0] word_turn_rate;
	logic [1:0]  lamp_action;

	// Predictor state, mirroring the parser of the block.
	rx_phase_t   rx_phase;
	logic [4:0]  rx_index;
	logic [7:0]  rx_payload [PAYLOAD_BYTES];

	frame_result_t frame_q[$];

	int  errors = 0;
	int  bytes_sent = 0;
	int  frames_expected = 0;
	int  lamp_count [3] = '{0, 0, 0};
	bit  calm = 1'b0;
	logic hold_request = 1'b0;
	string word_names [WORD_COUNT] = '{"word_yaw", "word_roll", "word_pitch",
		"word_pos_x", "word_pos_y", "word_turn_rate"};

	fixed_frame_deframer_six_words_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.word_yaw       (word_yaw),
		.word_roll      (word_roll),
		.word_pitch     (word_pitch),
		.word_pos_x     (word_pos_x),
		.word_pos_y     (word_pos_y),
		.word_turn_rate (word_turn_rate),
		.lamp_action    (lamp_action)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void track_rx_byte(input logic [7:0] b);
		frame_result_t f;
		logic z0, z3, z4;
		case (rx_phase)
			PH_HDR2: begin
				if (b == HDR_SECOND) begin
					rx_index = '0;
					rx_phase = PH_PAYLOAD;
				end else begin
					rx_phase = PH_HUNT;
				end
			end
			PH_PAYLOAD: begin
				rx_payload[rx_index] = b;
				if (rx_index == PAYLOAD_BYTES - 1) begin
					rx_index = '0;
					rx_phase = PH_TRL1;
				end else begin
					rx_index = rx_index + 5'd1;
				end
			end
			PH_TRL1: rx_phase = (b == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
			PH_TRL2: begin
				if (b == TRL_SECOND) begin
					for (int k = 0; k < WORD_COUNT; k++)
						f.words[k] = {rx_payload[4*k+3], rx_payload[4*k+2],
							rx_payload[4*k+1], rx_payload[4*k]};
					// The sign bit is ignored, so -0 counts as zero.
					z0 = (f.words[0][30:0] == '0);
					z3 = (f.words[3][30:0] == '0);
					z4 = (f.words[4][30:0] == '0);
					if (!z0 && !z3 && !z4)
						f.lamp = LAMP_ON;
					else if (z0 && z3 && z4)
						f.lamp = LAMP_OFF;
					else
						f.lamp = LAMP_LEAVE;
					frame_q.push_back(f);
					frames_expected++;
				end
				rx_phase = PH_HUNT;
			end
			default: rx_phase = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		track_rx_byte(b);
	endtask

	// Payload word k sits in bits 32*k+31..32*k, sent low byte first.
	task automatic send_frame(input logic [8*PAYLOAD_BYTES-1:0] payload,
			input logic [7:0] trl1, input logic [7:0] trl2);
		send_byte(HDR_FIRST);
		send_byte(HDR_SECOND);
		for (int i = 0; i < PAYLOAD_BYTES; i++)
			send_byte(payload[8*i +: 8]);
		send_byte(trl1);
		send_byte(trl2);
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(4))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [8*PAYLOAD_BYTES-1:0] random_payload();
		logic [8*PAYLOAD_BYTES-1:0] p;
		for (int k = 0; k < WORD_COUNT; k++)
			p[32*k +: 32] = random_word();
		return p;
	endfunction

	task automatic test_hunt_and_header();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HDR_SECOND);
		// A repeated first header byte does not resynchronize.
		send_byte(HDR_FIRST);
		send_byte(HDR_FIRST);
		send_byte(HDR_SECOND);
		send_byte(HDR_FIRST);
		send_byte(8'h55);
	endtask

	task automatic test_lamp_actions();
		send_frame('0, TRL_FIRST, TRL_SECOND);
		send_frame('1, TRL_FIRST, TRL_SECOND);
		send_frame({32'h1234_5678, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h0000_0001, 32'h8000_0000}, TRL_FIRST, TRL_SECOND);
		send_frame({32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h0000_0001}, TRL_FIRST, TRL_SECOND);
		send_frame({32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_0000,
			32'h0000_0000, 32'h3F80_0000}, TRL_FIRST, TRL_SECOND);
	endtask

	task automatic test_trailer_errors();
		send_frame(random_payload(), 8'h0B, TRL_SECOND);
		send_frame(random_payload(), TRL_FIRST, TRL_FIRST);
		send_frame(random_payload(), TRL_FIRST, 8'h00);
		send_frame(random_payload(), TRL_SECOND, TRL_FIRST);
		send_frame(random_payload(), TRL_FIRST, TRL_SECOND);
	endtask

	// The receiver stops taking frames while the sender keeps going, so the
	// block has to back up into its input.
	task automatic test_output_stall();
		calm = 1'b1;
		hold_request <= 1'b1;
		repeat (4)
			send_frame(random_payload(), TRL_FIRST, TRL_SECOND);
		calm = 1'b0;
	endtask

	task automatic test_random_traffic();
		int byte_goal;
		int frame_goal;
		int iter;
		int n;
		byte_goal  = bytes_sent + RANDOM_BYTES;
		frame_goal = frames_expected + RANDOM_MIN_FRAMES;
		iter = 0;
		while (bytes_sent < byte_goal || frames_expected < frame_goal) begin
			calm = (iter >= 12 && iter < 24);
			n = $urandom_range(99);
			if (n < 70) begin
				send_frame(random_payload(), TRL_FIRST, TRL_SECOND);
			end else if (n < 80) begin
				send_frame(random_payload(), $urandom_range(1) ? TRL_FIRST : 8'($urandom),
					8'($urandom));
			end else if (n < 88) begin
				send_byte(HDR_FIRST);
				send_byte(HDR_SECOND);
				repeat ($urandom_range(23))
					send_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(2))
						0: send_byte(HDR_FIRST);
						1: send_byte(HDR_SECOND);
						default: send_byte(8'($urandom));
					endcase
				end
			end
			iter++;
		end
		calm = 1'b0;
	endtask

	always @(posedge clk) begin : frame_check
		frame_result_t want;
		logic [31:0] seen [WORD_COUNT];
		int hold_left;
		bit hold_done;
		if (out_valid && out_ready) begin
			seen = '{word_yaw, word_roll, word_pitch, word_pos_x, word_pos_y,
				word_turn_rate};
			if (frame_q.size() == 0) begin
				$error("frame transaction with no frame expected");
				errors++;
			end else begin
				want = frame_q.pop_front();
				for (int k = 0; k < WORD_COUNT; k++) begin
					if (seen[k] !== want.words[k]) begin
						$error("%s: expected %h, actual %h", word_names[k],
							want.words[k], seen[k]);
						errors++;
					end
				end
				if (lamp_action !== want.lamp) begin
					$error("lamp_action: expected %0d, actual %0d", want.lamp, lamp_action);
					errors++;
				end
				if (want.lamp <= LAMP_OFF)
					lamp_count[want.lamp]++;
			end
		end
		if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin : watchdog
		int quiet;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", quiet);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		rx_byte  = 8'h00;
		rx_phase = PH_HUNT;
		rx_index = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_hunt_and_header();
		test_lamp_actions();
		test_trailer_errors();
		test_output_stall();
		test_random_traffic();

		in_valid <= 1'b0;
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d bytes sent, %0d frames predicted and checked",
			bytes_sent, frames_expected);
		$display("summary: lamp on %0d, off %0d, leave %0d; one long output stall",
			lamp_count[LAMP_ON], lamp_count[LAMP_OFF], lamp_count[LAMP_LEAVE]);
		if (errors == 0 && frame_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
rtl/ffd_pkg.sv
rtl/ffd_parser.sv
rtl/ffd_result.sv
rtl/fixed_frame_deframer_six_words_core.sv
tb/sv/fixed_frame_deframer_six_words_core_tb.sv
